// ----- hw/rtl/control_tick_deadline_watchdog_core_macros.svh -----
// ----------------------------------------------------------------------------
// Watchdog assertion macros
// Shared concurrent assertion forms for the watchdog checker.
// ----------------------------------------------------------------------------
`ifndef CONTROL_TICK_DEADLINE_WATCHDOG_CORE_MACROS_SVH
`define CONTROL_TICK_DEADLINE_WATCHDOG_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CTDW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("watchdog assertion failed");

// next-cycle implication, disabled in reset
`define CTDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("watchdog assertion failed");

`endif

// ----- hw/rtl/ctdw_pkg.sv -----
// ----------------------------------------------------------------------------
// Watchdog package
// Event kinds, register indexes, reset values and stream field positions.
// ----------------------------------------------------------------------------
package ctdw_pkg;

	typedef enum logic [1:0] {
		KIND_ARM    = 2'd0,
		KIND_BEAT   = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_DISARM = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		CFG_MAX_TICK_GAP = 1'b0,
		CFG_HB_TIMEOUT   = 1'b1
	} cfg_idx_t;

	localparam int CFG_W       = 32;
	localparam int COUNT_W     = 32;
	localparam int TICK_TIME_W = 64;

	localparam logic [CFG_W-1:0] MAX_TICK_GAP_RST = 32'd2000;
	localparam logic [CFG_W-1:0] HB_TIMEOUT_RST   = 32'd100000;

	// slave stream: tdata = now_time, permit; tuser = kind
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 2;
	localparam int PERMIT_BIT = 64;

	// master stream: tdata = arm_accepted, run_control, tick_time,
	// stop_request, is_armed, is_faulted, tick_total
	localparam int M_TDATA_W      = 104;
	localparam int OUT_ARM_BIT    = 0;
	localparam int OUT_RUN_BIT    = 1;
	localparam int OUT_TIME_LSB   = 2;
	localparam int OUT_STOP_BIT   = 66;
	localparam int OUT_ARMED_BIT  = 67;
	localparam int OUT_FAULT_BIT  = 68;
	localparam int OUT_COUNT_LSB  = 69;

	typedef struct packed {
		logic arm_accepted;
		logic run_control;
		logic stop_request;
	} evt_flags_t;

endpackage

// ----- hw/rtl/control_tick_deadline_watchdog_core.sv -----
// ----------------------------------------------------------------------------
// Control tick deadline watchdog
// Path from input accept to result valid: input reg, then result reg.
// Throughput: one item per cycle while the result side is not stalled; the
// state update is a single pass of compare/subtract logic between the
// input register and the result register.
// Reset (arst_n low, async): disarmed, no fault, stored times and tick count
// zero, limits back to 2000 us and 100000 us, both stream stages empty.
// ----------------------------------------------------------------------------
module control_tick_deadline_watchdog_core #(
	parameter int TIME_WIDTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// event stream in
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [ctdw_pkg::S_TDATA_W-1:0]       s_tdata,  // [63:0] now_time, [64] permit
	input  logic [ctdw_pkg::S_TUSER_W-1:0]       s_tuser,  // [1:0] kind
	// result stream out
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] arm_accepted, [1] run_control, [65:2] tick_time, [66] stop_request,
	// [67] is_armed, [68] is_faulted, [100:69] tick_total
	output logic [ctdw_pkg::M_TDATA_W-1:0]       m_tdata,
	// register write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  ctdw_pkg::cfg_idx_t                   cfg_index,
	input  logic [ctdw_pkg::CFG_W-1:0]           cfg_data
);
	import ctdw_pkg::*;

	// limits
	logic [CFG_W-1:0]      max_tick_gap_q;
	logic [CFG_W-1:0]      hb_timeout_q;

	// watchdog state
	logic                  armed_q;
	logic                  fault_q;
	logic [TIME_WIDTH-1:0] last_tick_q;
	logic [TIME_WIDTH-1:0] last_beat_q;
	logic [COUNT_W-1:0]    tick_ctr_q;

	// input stage
	logic                  valid_s1;
	kind_t                 kind_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  permit_s1;

	// result stage
	logic                  out_valid_q;
	logic [M_TDATA_W-1:0]  out_data_q;

	// evaluation results
	logic                  armed_nxt;
	logic                  fault_nxt;
	logic [TIME_WIDTH-1:0] last_tick_nxt;
	logic [TIME_WIDTH-1:0] last_beat_nxt;
	logic [COUNT_W-1:0]    tick_ctr_nxt;
	evt_flags_t            flags;
	logic [TICK_TIME_W-1:0] tick_time;

	logic                  advance;
	logic                  in_fire;

	// The held event moves into the result register whenever that register
	// is empty or being drained this cycle; the input stage refills at once,
	// so back-to-back events stream at one per cycle while results are taken.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_fire  = s_tvalid && s_tready;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// limit registers; the user must write only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tick_gap_q <= MAX_TICK_GAP_RST;
			hb_timeout_q   <= HB_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_TICK_GAP: max_tick_gap_q <= cfg_data;
				CFG_HB_TIMEOUT:   hb_timeout_q   <= cfg_data;
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload; only low TIME_WIDTH bits of the time are used
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1   <= kind_t'(s_tuser);
			now_s1    <= s_tdata[TIME_WIDTH-1:0];
			permit_s1 <= s_tdata[PERMIT_BIT];
		end
	end

	ctdw_eval #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_eval (
		.kind              (kind_s1),
		.now_time          (now_s1),
		.permit            (permit_s1),
		.max_tick_gap      (max_tick_gap_q),
		.heartbeat_timeout (hb_timeout_q),
		.armed             (armed_q),
		.faulted           (fault_q),
		.last_tick         (last_tick_q),
		.last_beat         (last_beat_q),
		.tick_ctr          (tick_ctr_q),
		.armed_nxt         (armed_nxt),
		.faulted_nxt       (fault_nxt),
		.last_tick_nxt     (last_tick_nxt),
		.last_beat_nxt     (last_beat_nxt),
		.tick_ctr_nxt      (tick_ctr_nxt),
		.flags             (flags),
		.tick_time         (tick_time)
	);

	// state commits together with the result of the event that changed it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			fault_q     <= 1'b0;
			last_tick_q <= '0;
			last_beat_q <= '0;
			tick_ctr_q  <= '0;
		end else if (advance) begin
			armed_q     <= armed_nxt;
			fault_q     <= fault_nxt;
			last_tick_q <= last_tick_nxt;
			last_beat_q <= last_beat_nxt;
			tick_ctr_q  <= tick_ctr_nxt;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, packed lowest field first
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {3'b000, tick_ctr_nxt, fault_nxt, armed_nxt,
				flags.stop_request, tick_time, flags.run_control,
				flags.arm_accepted};
		end
	end

endmodule

// ----- hw/rtl/ctdw_eval.sv -----
// ----------------------------------------------------------------------------
// Watchdog event evaluation
// Next state and result flags for one event against the current state.
// ----------------------------------------------------------------------------
module ctdw_eval #(
	parameter int TIME_WIDTH = 64
) (
	input  ctdw_pkg::kind_t                       kind,
	input  logic [TIME_WIDTH-1:0]                 now_time,
	input  logic                                  permit,
	input  logic [ctdw_pkg::CFG_W-1:0]            max_tick_gap,
	input  logic [ctdw_pkg::CFG_W-1:0]            heartbeat_timeout,
	input  logic                                  armed,
	input  logic                                  faulted,
	input  logic [TIME_WIDTH-1:0]                 last_tick,
	input  logic [TIME_WIDTH-1:0]                 last_beat,
	input  logic [ctdw_pkg::COUNT_W-1:0]          tick_ctr,
	output logic                                  armed_nxt,
	output logic                                  faulted_nxt,
	output logic [TIME_WIDTH-1:0]                 last_tick_nxt,
	output logic [TIME_WIDTH-1:0]                 last_beat_nxt,
	output logic [ctdw_pkg::COUNT_W-1:0]          tick_ctr_nxt,
	output ctdw_pkg::evt_flags_t                  flags,
	output logic [ctdw_pkg::TICK_TIME_W-1:0]      tick_time
);
	import ctdw_pkg::*;

	// compare width covers both the time and the 32-bit limits
	localparam int DW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

	logic [TIME_WIDTH-1:0] tick_gap;
	logic [TIME_WIDTH-1:0] beat_age;
	logic                  tick_back;
	logic                  beat_back;
	logic                  gap_over;
	logic                  age_over;

	assign tick_gap  = now_time - last_tick;
	assign beat_age  = now_time - last_beat;
	assign tick_back = now_time < last_tick;
	assign beat_back = now_time < last_beat;
	assign gap_over  = DW'(tick_gap) > DW'(max_tick_gap);
	assign age_over  = DW'(beat_age) > DW'(heartbeat_timeout);

	always_comb begin
		armed_nxt     = armed;
		faulted_nxt   = faulted;
		last_tick_nxt = last_tick;
		last_beat_nxt = last_beat;
		tick_ctr_nxt  = tick_ctr;
		flags         = '0;
		unique case (kind)
			KIND_ARM: begin
				if (permit && !faulted) begin
					last_tick_nxt      = now_time;
					last_beat_nxt      = now_time;
					armed_nxt          = 1'b1;
					flags.arm_accepted = 1'b1;
				end
			end
			KIND_BEAT: begin
				if (armed) begin
					if (!permit || beat_back) begin
						armed_nxt          = 1'b0;
						faulted_nxt        = 1'b1;
						flags.stop_request = 1'b1;
					end else begin
						last_beat_nxt = now_time;
					end
				end
			end
			KIND_TICK: begin
				if (armed) begin
					if (!permit || tick_back || beat_back || gap_over || age_over) begin
						armed_nxt          = 1'b0;
						faulted_nxt        = 1'b1;
						flags.stop_request = 1'b1;
					end else begin
						last_tick_nxt     = now_time;
						tick_ctr_nxt      = tick_ctr + 1'b1;
						flags.run_control = 1'b1;
					end
				end
			end
			KIND_DISARM: begin
				armed_nxt          = 1'b0;
				flags.stop_request = 1'b1;
			end
		endcase
	end

	assign tick_time = flags.run_control ? TICK_TIME_W'(now_time) : '0;

endmodule

// ----- hw/rtl/ctdw_checker.sv -----
// ----------------------------------------------------------------------------
// Watchdog port checker
// Result consistency and output hold checks, bound to the core.
// ----------------------------------------------------------------------------
`include "control_tick_deadline_watchdog_core_macros.svh"

module ctdw_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [ctdw_pkg::M_TDATA_W-1:0]       m_tdata
);
	import ctdw_pkg::*;

	logic run_o;
	logic arm_o;
	logic stop_o;
	logic armed_o;
	logic fault_o;
	logic [TICK_TIME_W-1:0] time_o;

	assign run_o   = m_tdata[OUT_RUN_BIT];
	assign arm_o   = m_tdata[OUT_ARM_BIT];
	assign stop_o  = m_tdata[OUT_STOP_BIT];
	assign armed_o = m_tdata[OUT_ARMED_BIT];
	assign fault_o = m_tdata[OUT_FAULT_BIT];
	assign time_o  = m_tdata[OUT_TIME_LSB +: TICK_TIME_W];

	// a fired control step leaves the watchdog armed and healthy
	`CTDW_ASSERT_SAME(a_run_armed, clk, arst_n, m_tvalid && run_o, armed_o && !fault_o && !stop_o)

	// a successful arm never comes with a stop or a fault
	`CTDW_ASSERT_SAME(a_arm_clean, clk, arst_n, m_tvalid && arm_o, armed_o && !fault_o && !stop_o)

	// tick time is only handed out with a fired step
	`CTDW_ASSERT_SAME(a_time_zero, clk, arst_n, m_tvalid && !run_o, time_o == '0)

	// a stalled result holds
	`CTDW_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind control_tick_deadline_watchdog_core ctdw_checker u_ctdw_checker (.*);

// ----- tb/deadline_tracker_pkg.sv -----
// ----------------------------------------------------------------------------
// Deadline tracker
// Predicts the watchdog's result item for each accepted event and checks the
// result items coming out of the block against those predictions, in order.
// ----------------------------------------------------------------------------
package deadline_tracker_pkg;

	import ctdw_pkg::*;

	typedef struct {
		logic        arm_ok;
		logic        run;
		logic [63:0] run_time;
		logic        stop;
		logic        armed;
		logic        faulted;
		logic [31:0] ticks;
	} verdict_t;

	class deadline_tracker;
		logic [31:0] gap_limit;
		logic [31:0] beat_limit;
		logic        armed;
		logic        faulted;
		logic [63:0] last_tick;
		logic [63:0] last_beat;
		logic [31:0] ticks;
		int          errors;
		verdict_t    verdicts[$];

		function new();
			gap_limit  = MAX_TICK_GAP_RST;
			beat_limit = HB_TIMEOUT_RST;
			armed      = 1'b0;
			faulted    = 1'b0;
			last_tick  = '0;
			last_beat  = '0;
			ticks      = '0;
			errors     = 0;
		endfunction

		function void set_limit(cfg_idx_t idx, logic [31:0] value);
			if (idx == CFG_MAX_TICK_GAP) begin
				gap_limit = value;
			end else begin
				beat_limit = value;
			end
		endfunction

		function int verdicts_due();
			return verdicts.size();
		endfunction

		function void note_event(kind_t kind, logic [63:0] now, logic permit);
			verdict_t v;
			logic     trip;
			v = '{default: '0};
			trip = 1'b0;
			case (kind)
				KIND_ARM: begin
					if (permit && !faulted) begin
						last_tick = now;
						last_beat = now;
						armed     = 1'b1;
						v.arm_ok  = 1'b1;
					end
				end
				KIND_BEAT: begin
					if (armed) begin
						if (!permit || now < last_beat) begin
							trip = 1'b1;
						end else begin
							last_beat = now;
						end
					end
				end
				KIND_TICK: begin
					if (armed) begin
						if (!permit || now < last_tick || now < last_beat) begin
							trip = 1'b1;
						end else if ((now - last_tick) > {32'd0, gap_limit} ||
								(now - last_beat) > {32'd0, beat_limit}) begin
							trip = 1'b1;
						end else begin
							last_tick  = now;
							ticks      = ticks + 32'd1;
							v.run      = 1'b1;
							v.run_time = now;
						end
					end
				end
				default: begin
					armed  = 1'b0;
					v.stop = 1'b1;
				end
			endcase
			if (trip) begin
				armed   = 1'b0;
				faulted = 1'b1;
				v.stop  = 1'b1;
			end
			v.armed   = armed;
			v.faulted = faulted;
			v.ticks   = ticks;
			verdicts.push_back(v);
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_verdict(logic [M_TDATA_W-1:0] data);
			verdict_t v;
			if (verdicts.size() == 0) begin
				$error("result item with no event pending");
				errors++;
				return;
			end
			v = verdicts.pop_front();
			compare("arm_accepted", 64'(v.arm_ok), 64'(data[OUT_ARM_BIT]));
			compare("run_control", 64'(v.run), 64'(data[OUT_RUN_BIT]));
			compare("tick_time", v.run_time, data[OUT_TIME_LSB +: TICK_TIME_W]);
			compare("stop_request", 64'(v.stop), 64'(data[OUT_STOP_BIT]));
			compare("is_armed", 64'(v.armed), 64'(data[OUT_ARMED_BIT]));
			compare("is_faulted", 64'(v.faulted), 64'(data[OUT_FAULT_BIT]));
			compare("tick_total", 64'(v.ticks), 64'(data[OUT_COUNT_LSB +: COUNT_W]));
		endfunction
	endclass

endpackage

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Watchdog core testbench
// Drives arm/heartbeat/tick/disarm events into the core under several limit
// settings and random stalls on both streams, and checks every result item
// against a cycle-free prediction of the watchdog state.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ctdw_pkg::*;
	import deadline_tracker_pkg::*;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;  // [63:0] now_time, [64] permit
	logic [S_TUSER_W-1:0] s_tuser   = '0;  // [1:0] kind
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// [0] arm_accepted, [1] run_control, [65:2] tick_time, [66] stop_request,
	// [67] is_armed, [68] is_faulted, [100:69] tick_total
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	cfg_idx_t             cfg_index = CFG_MAX_TICK_GAP;
	logic [CFG_W-1:0]     cfg_data  = '0;

	deadline_tracker scb;

	// percent of cycles each side sits idle
	int send_idle = 0;
	int recv_idle = 0;

	// bumped by the main flow to make the result side hold off for a while
	int hold_token = 0;

	localparam int        HOLD_CYCLES = 300;
	localparam int        DRAIN_SLACK = 4;
	localparam logic [63:0] TIME_MAX  = '1;

	control_tick_deadline_watchdog_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the core hangs or drops items
	initial begin
		#2_000_000;
		$display("FAIL control_tick_deadline_watchdog_core");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: check each accepted item, then pick tready for the next
	// cycle. A hold request forces tready low until hold_left, loaded from
	// HOLD_CYCLES, counts down, so the core backs up and has to stall its input.
	// ------------------------------------------------------------------------
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				scb.check_verdict(m_tdata);
			end
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Event side
	// ------------------------------------------------------------------------

	// Offer one event, with a random idle gap in front, and log it with the
	// tracker at the edge where it is taken. Entered and left at a clock edge.
	task automatic send_event(kind_t kind, logic [63:0] now, logic permit);
		logic [S_TDATA_W-1:0] d;
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		d = '0;
		d[63:0] = now;
		d[PERMIT_BIT] = permit;
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= kind;
		do @(posedge clk); while (s_tready !== 1'b1);
		scb.note_event(kind, now, permit);
	endtask

	// Stop offering and wait until every predicted item has come back, then
	// wait out DRAIN_SLACK so the pipe is empty before any register write.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (scb.verdicts_due() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Both limits back to back; valid stays up between the two items.
	task automatic write_limits(logic [31:0] gap, logic [31:0] beat);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MAX_TICK_GAP;
		cfg_data  <= gap;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		scb.set_limit(CFG_MAX_TICK_GAP, gap);
		cfg_index <= CFG_HB_TIMEOUT;
		cfg_data  <= beat;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		scb.set_limit(CFG_HB_TIMEOUT, beat);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// arm times: near zero, near the top of the range, or anywhere
	function automatic logic [63:0] arm_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return 64'($urandom_range(0, 10000));
		if (r < 45) return TIME_MAX - 64'($urandom_range(0, 100000));
		return rand64();
	endfunction

	// value in [lo, hi], leaning on both ends and on short steps
	function automatic logic [63:0] pick_between(logic [63:0] lo, logic [63:0] hi);
		logic [64:0] span;
		int          r;
		span = {1'b0, hi} - {1'b0, lo} + 65'd1;
		r = $urandom_range(0, 9);
		if (r < 2) return lo;
		if (r < 4) return hi;
		if (r < 7 && span > 65'd64) return lo + 64'($urandom_range(0, 63));
		return lo + 64'({1'b0, rand64()} % span);
	endfunction

	// Latest time a tick may carry and still pass both limits.
	function automatic logic [64:0] tick_ceiling();
		logic [64:0] by_gap;
		logic [64:0] by_beat;
		logic [64:0] hi;
		by_gap  = {1'b0, scb.last_tick} + {33'd0, scb.gap_limit};
		by_beat = {1'b0, scb.last_beat} + {33'd0, scb.beat_limit};
		hi = (by_gap < by_beat) ? by_gap : by_beat;
		return (hi > {1'b0, TIME_MAX}) ? {1'b0, TIME_MAX} : hi;
	endfunction

	function automatic logic [63:0] tick_floor();
		return (scb.last_tick > scb.last_beat) ? scb.last_tick : scb.last_beat;
	endfunction

	// Well-formed traffic: arm, then heartbeats and ticks whose times stay
	// inside the current windows, so the core never trips and keeps firing.
	// Heartbeats never move past last_tick + gap, which keeps the next tick
	// window non-empty.
	function automatic void gen_safe(output kind_t kind, output logic [63:0] now,
			output logic permit);
		logic [64:0] tick_hi;
		logic [64:0] beat_hi;
		logic [63:0] lo;
		int          r;
		r       = $urandom_range(0, 99);
		lo      = tick_floor();
		tick_hi = tick_ceiling();
		beat_hi = {1'b0, scb.last_tick} + {33'd0, scb.gap_limit};
		if (beat_hi > {1'b0, TIME_MAX}) beat_hi = {1'b0, TIME_MAX};
		permit = 1'b1;
		if (!scb.armed) begin
			if (r < 80) begin
				kind = KIND_ARM;
				now  = arm_time();
			end else if (r < 85) begin
				// refused arm
				kind   = KIND_ARM;
				now    = rand64();
				permit = 1'b0;
			end else begin
				kind   = kind_t'($urandom_range(1, 3));
				now    = rand64();
				permit = 1'($urandom_range(0, 1));
			end
		end else if (r < 6 || {1'b0, lo} > tick_hi) begin
			// re-arm reloads both times; also recovers from a window that a
			// new limit setting has closed
			kind = KIND_ARM;
			now  = arm_time();
		end else if (r < 9) begin
			kind   = KIND_ARM;
			now    = rand64();
			permit = 1'b0;
		end else if (r < 40) begin
			kind = KIND_BEAT;
			now  = pick_between(scb.last_beat, beat_hi[63:0]);
		end else if (r < 96) begin
			kind = KIND_TICK;
			now  = pick_between(lo, tick_hi[63:0]);
		end else begin
			kind   = KIND_DISARM;
			now    = rand64();
			permit = 1'($urandom_range(0, 1));
		end
	endfunction

	// One event that trips the armed watchdog. The latch only clears on
	// reset, so a run gets exactly one trip; its cause is picked at random,
	// with a tick running backwards the most likely.
	function automatic void gen_trip(output kind_t kind, output logic [63:0] now,
			output logic permit);
		logic [64:0] tick_hi;
		logic [63:0] lo;
		int          cause;
		cause   = $urandom_range(0, 7);
		lo      = tick_floor();
		tick_hi = tick_ceiling();
		kind    = KIND_TICK;
		now     = lo;
		permit  = 1'b0;
		if (cause < 4) begin
			if (lo != 0) begin
				now    = lo - 64'd1;
				permit = 1'b1;
			end
		end else if (cause == 4) begin
			kind = KIND_BEAT;
			now  = scb.last_beat;
			if (scb.last_beat != 0) begin
				now    = scb.last_beat - 64'd1;
				permit = 1'b1;
			end
		end else if (cause == 5) begin
			kind = KIND_BEAT;
			now  = scb.last_beat;
		end else if (cause == 7) begin
			// one microsecond past the tighter of the two limits
			if (tick_hi < {1'b0, TIME_MAX}) begin
				now    = tick_hi[63:0] + 64'd1;
				permit = 1'b1;
			end
		end
	endfunction

	function automatic void gen_noise(output kind_t kind, output logic [63:0] now,
			output logic permit);
		kind   = kind_t'($urandom_range(0, 3));
		permit = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 1) == 0) begin
			now = rand64();
		end else begin
			now = scb.last_tick + 64'($urandom_range(0, 4000)) - 64'd2000;
		end
	endfunction

	task automatic run_safe(int count);
		kind_t       kind;
		logic [63:0] now;
		logic        permit;
		int          n;
		n = 0;
		while (n < count) begin
			gen_safe(kind, now, permit);
			n++;
			send_event(kind, now, permit);
		end
	endtask

	// Closing phase: a short healthy stretch, the single trip, then random
	// events against the latched fault (refused arms, disarm while faulted).
	task automatic run_final(int count);
		kind_t       kind;
		logic [63:0] now;
		logic        permit;
		int          n;
		send_event(KIND_ARM, arm_time(), 1'b1);
		repeat (12) begin
			gen_safe(kind, now, permit);
			send_event(kind, now, permit);
		end
		if (!scb.armed) send_event(KIND_ARM, arm_time(), 1'b1);
		gen_trip(kind, now, permit);
		send_event(kind, now, permit);
		n = 0;
		while (n < count) begin
			gen_noise(kind, now, permit);
			n++;
			send_event(kind, now, permit);
		end
	endtask

	// ------------------------------------------------------------------------
	// Main flow
	// ------------------------------------------------------------------------
	initial begin
		scb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 37;
		recv_idle = 81;

		// Directed events under the reset limits (gap 2000, heartbeat 100000).
		send_event(KIND_BEAT,   64'd5,     1'b1);  // disarmed: ignored
		send_event(KIND_TICK,   64'd10,    1'b1);  // disarmed: ignored
		send_event(KIND_DISARM, 64'd0,     1'b0);  // disarm while disarmed
		send_event(KIND_ARM,    64'd100,   1'b0);  // refused, not permissive
		send_event(KIND_ARM,    64'd1000,  1'b1);
		send_event(KIND_TICK,   64'd1000,  1'b1);  // zero gap
		send_event(KIND_BEAT,   64'd1500,  1'b1);
		send_event(KIND_TICK,   64'd3000,  1'b1);  // gap exactly at the limit
		send_event(KIND_ARM,    64'd1,     1'b0);  // refused while armed
		send_event(KIND_BEAT,   64'd3000,  1'b1);  // same time as last tick
		send_event(KIND_ARM,    64'd50000, 1'b1);  // re-arm reloads times
		send_event(KIND_TICK,   64'd52000, 1'b1);
		send_event(KIND_BEAT,   64'd53000, 1'b1);
		send_event(KIND_TICK,   64'd54000, 1'b1);
		send_event(KIND_DISARM, 64'd54000, 1'b1);
		send_event(KIND_TICK,   64'd54001, 1'b1);  // ignored after disarm
		send_event(KIND_ARM,    TIME_MAX,  1'b1);  // top of the time range
		send_event(KIND_TICK,   TIME_MAX,  1'b1);
		send_event(KIND_BEAT,   TIME_MAX,  1'b1);
		send_event(KIND_DISARM, TIME_MAX,  1'b0);
		send_event(KIND_ARM,    64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		send_event(KIND_BEAT,   64'hAAAA_AAAA_AAAA_ABAA, 1'b1);
		send_event(KIND_TICK,   64'hAAAA_AAAA_AAAA_B27A, 1'b1);
		send_event(KIND_DISARM, 64'h5555_5555_5555_5555, 1'b1);
		settle();

		// Sender sparse-ish, receiver mostly stalled.
		write_limits(32'($urandom_range(50, 5000)), 32'($urandom_range(1000, 200000)));
		run_safe(290);
		settle();
		write_limits(32'd0, 32'd0);  // both limits at zero: no time may pass
		run_safe(290);
		settle();

		// Roles swapped.
		send_idle = 81;
		recv_idle = 37;
		write_limits('1, '1);
		run_safe(290);
		settle();
		write_limits($urandom, 32'($urandom_range(0, 3000)));
		run_safe(290);
		settle();

		// No idling; the result side holds off at the start so the core
		// fills up and pushes back on the event stream.
		send_idle = 0;
		recv_idle = 0;
		write_limits('1, 32'($urandom_range(0, 100)));
		hold_token <= hold_token + 1;
		run_safe(290);
		settle();
		write_limits(MAX_TICK_GAP_RST, HB_TIMEOUT_RST);
		run_final(300);
		settle();

		if (scb.errors == 0) begin
			$display("PASS control_tick_deadline_watchdog_core");
		end else begin
			$display("FAIL control_tick_deadline_watchdog_core");
		end
		$finish;
	end

endmodule
